>>> design/btcr_pkg.sv
// Shared types and constants for the bitmap text console renderer.
package btcr_pkg;

    localparam int MAX_GLYPH_ROWS        = 32;
    localparam int GLYPH_ROW_AW          = $clog2(MAX_GLYPH_ROWS);
    localparam int BYTES_PER_PIXEL_SHIFT = 2;
    localparam int CODE_W                = 8;
    localparam int STORE_AW              = CODE_W + GLYPH_ROW_AW;
    localparam int STORE_DEPTH           = 1 << STORE_AW;
    localparam int HEIGHT_W              = 6;
    localparam int WIDTH_W               = 4;
    localparam int DIM_W                 = 11;
    localparam int CUR_W                 = 10;
    localparam int PITCH_W               = 16;
    localparam int OFFSET_W              = 26;
    localparam int COLOR_W               = 32;
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 32;
    localparam int S_TDATA_W             = 32;
    localparam int M_TDATA_W             = 88;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR    = 3'd5;

    // Actions carried in tuser.
    localparam logic ACT_PUT_CHAR    = 1'b0;
    localparam logic ACT_GLYPH_WRITE = 1'b1;

    // Control characters.
    localparam logic [CODE_W-1:0] CHAR_NUL       = 8'd0;
    localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;

    localparam logic [COLOR_W-1:0] BLACK = 32'h0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_NORM,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } state_t;

endpackage

>>> design/bitmap_text_console_renderer.sv
// Bitmap text console renderer: cursor sequencer, glyph memory and row write stream.
// One character code per s_axis transaction; a printable code or a backspace produces
// one m_axis transaction per glyph line (glyph_height lines, capped at 32), one line
// per cycle while the output is taken. After the accepting cycle the sequencer passes
// through the cursor update, the cell offset multiply and add, and then the glyph
// memory reads. When the column runs past the right edge a restoring remainder unit
// wraps it before the cursor update. Glyph store writes, NUL and a newline produce
// no output.
// The glyph memory has a single read port, and that port paces the line output.
// The glyph memory has no reset; every glyph line that is drawn must be loaded first.
module bitmap_text_console_renderer (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: char_code[7:0], glyph_address[20:8], glyph_byte[28:21], zero[31:29]
    input  logic [btcr_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: action (0 put character, 1 glyph store write)
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: row_byte_offset[25:0], pixel_bits[33:26], pixel_color[65:34],
    //          cursor_row_now[75:66], cursor_col_now[85:76], zero[87:86]
    output logic [btcr_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tlast: last_row
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [btcr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import btcr_pkg::*;

    localparam int PH_W = PITCH_W + HEIGHT_W;
    localparam int CT_W = CUR_W + WIDTH_W + BYTES_PER_PIXEL_SHIFT;

    // Configuration registers.
    logic [PITCH_W-1:0]  pitch_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [DIM_W-1:0]    cols_reg;
    logic [DIM_W-1:0]    rows_reg;
    logic [COLOR_W-1:0]  ink_reg;

    state_t state_reg, state_next;

    logic [CUR_W-1:0]    cur_row_reg, cur_col_reg;
    logic [CUR_W-1:0]    off_row_reg, off_col_reg;
    logic [DIM_W-1:0]    work_row_reg, work_col_reg;
    logic                emit_reg, blank_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [DIM_W-1:0]    num_reg, rem_reg;
    logic [3:0]          div_cnt_reg;
    logic [PH_W-1:0]     ph_reg;
    logic [OFFSET_W-1:0] base_reg, off_reg;
    logic [CT_W-1:0]     colterm_reg;
    logic [HEIGHT_W-1:0] rd_y_reg, em_y_reg;
    logic                rd_pend_reg;
    logic [7:0]          glyph_rd_reg;

    logic [7:0] glyph_mem [STORE_DEPTH];

    logic                m_tvalid_reg, m_tlast_reg;
    logic [OFFSET_W-1:0] out_off_reg;
    logic [7:0]          out_bits_reg;
    logic [COLOR_W-1:0]  out_color_reg;
    logic [CUR_W-1:0]    out_row_reg, out_col_reg;

    // Effective configuration values.
    logic [DIM_W-1:0]    cols_eff, rows_eff;
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;

    logic                s_accept, put_accept, glyph_wr;
    logic [CODE_W-1:0]   in_code;
    logic [STORE_AW-1:0] in_gaddr;
    logic [7:0]          in_gbyte;
    logic [DIM_W-1:0]    acc_row, acc_col;
    logic                acc_wrap;
    logic [DIM_W-1:0]    div_trial;
    logic [DIM_W-1:0]    row_clamped;
    logic                load, rd_issue, last_load;
    logic [7:0]          glyph_mask, glyph_bits;
    logic [STORE_AW-1:0] rd_addr;

    always_comb
    begin
        cols_eff   = (cols_reg == '0) ? DIM_W'(1)
                   : ((cols_reg > DIM_W'(1024)) ? DIM_W'(1024) : cols_reg);
        rows_eff   = (rows_reg == '0) ? DIM_W'(1)
                   : ((rows_reg > DIM_W'(1024)) ? DIM_W'(1024) : rows_reg);
        width_eff  = (width_reg > WIDTH_W'(8)) ? WIDTH_W'(8) : width_reg;
        height_eff = (height_reg > HEIGHT_W'(MAX_GLYPH_ROWS)) ? HEIGHT_W'(MAX_GLYPH_ROWS)
                   : height_reg;
    end

    assign in_code    = s_tdata[7:0];
    assign in_gaddr   = s_tdata[20:8];
    assign in_gbyte   = s_tdata[28:21];
    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign s_accept   = s_tvalid && s_tready;
    assign glyph_wr   = s_accept && (s_tuser == ACT_GLYPH_WRITE);
    assign put_accept = s_accept && (s_tuser == ACT_PUT_CHAR) && (in_code != CHAR_NUL);

    // Cursor before normalization, for the character being accepted.
    always_comb
    begin
        acc_row = DIM_W'(cur_row_reg);
        acc_col = DIM_W'(cur_col_reg) + DIM_W'(1);
        unique case (in_code)
            CHAR_NEWLINE:
            begin
                acc_row = DIM_W'(cur_row_reg) + DIM_W'(1);
                acc_col = '0;
            end
            CHAR_BACKSPACE:
            begin
                if (cur_col_reg != '0)
                begin
                    acc_col = DIM_W'(cur_col_reg) - DIM_W'(1);
                end
                else if (cur_row_reg != '0)
                begin
                    acc_row = DIM_W'(cur_row_reg) - DIM_W'(1);
                    acc_col = cols_eff - DIM_W'(1);
                end
                else
                begin
                    acc_col = '0;
                end
            end
            default:
            begin
            end
        endcase
        acc_wrap = (acc_col >= cols_eff);
    end

    assign div_trial   = {rem_reg[DIM_W-2:0], num_reg[DIM_W-1]};
    assign row_clamped = (work_row_reg >= rows_eff) ? (rows_eff - DIM_W'(1)) : work_row_reg;

    // Line pipeline: one glyph memory read in flight ahead of the output register.
    assign load      = (state_reg == ST_EMIT) && rd_pend_reg && (!m_tvalid_reg || m_tready);
    assign rd_issue  = (state_reg == ST_EMIT) && (rd_y_reg < height_eff)
                     && (!rd_pend_reg || load);
    assign last_load = load && (em_y_reg == height_eff - HEIGHT_W'(1));
    assign rd_addr   = {code_reg, rd_y_reg[GLYPH_ROW_AW-1:0]};

    always_comb
    begin
        glyph_mask = 8'((9'd1 << width_eff) - 9'd1);
        glyph_bits = 8'({8'd0, glyph_rd_reg & glyph_mask} << (WIDTH_W'(8) - width_eff));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (put_accept)
                begin
                    state_next = acc_wrap ? ST_DIV : ST_NORM;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                state_next = emit_reg ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = (height_eff == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (last_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= PITCH_W'(4096);
            height_reg <= HEIGHT_W'(16);
            width_reg  <= WIDTH_W'(8);
            cols_reg   <= DIM_W'(128);
            rows_reg   <= DIM_W'(48);
            ink_reg    <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LINE_PITCH:   pitch_reg  <= cfg_data[PITCH_W-1:0];
                CFG_GLYPH_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_GLYPH_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_TEXT_COLS:    cols_reg   <= cfg_data[DIM_W-1:0];
                CFG_TEXT_ROWS:    rows_reg   <= cfg_data[DIM_W-1:0];
                CFG_INK_COLOR:    ink_reg    <= cfg_data[COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            div_cnt_reg  <= '0;
            rd_y_reg     <= '0;
            em_y_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            emit_reg     <= 1'b0;
            blank_reg    <= 1'b0;
        end
        else
        begin
            if (put_accept)
            begin
                emit_reg    <= (in_code != CHAR_NEWLINE);
                blank_reg   <= (in_code == CHAR_BACKSPACE);
                div_cnt_reg <= 4'(DIM_W - 1);
            end
            else if (state_reg == ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg - 4'd1;
            end

            if (state_reg == ST_NORM)
            begin
                cur_row_reg <= row_clamped[CUR_W-1:0];
                cur_col_reg <= work_col_reg[CUR_W-1:0];
            end

            if (state_reg == ST_ADD)
            begin
                rd_y_reg    <= '0;
                em_y_reg    <= '0;
                rd_pend_reg <= 1'b0;
            end
            else
            begin
                if (rd_issue)
                begin
                    rd_y_reg    <= rd_y_reg + HEIGHT_W'(1);
                    rd_pend_reg <= 1'b1;
                end
                else if (load)
                begin
                    rd_pend_reg <= 1'b0;
                end
                if (load)
                begin
                    em_y_reg <= em_y_reg + HEIGHT_W'(1);
                end
            end

            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ph_reg <= PH_W'(pitch_reg * height_reg);

        if (put_accept)
        begin
            code_reg     <= in_code;
            off_row_reg  <= cur_row_reg;
            off_col_reg  <= cur_col_reg;
            work_col_reg <= acc_col;
            work_row_reg <= acc_wrap ? (acc_row + DIM_W'(1)) : acc_row;
            num_reg      <= acc_col;
            rem_reg      <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            // Restoring remainder, one dividend bit per cycle.
            num_reg <= {num_reg[DIM_W-2:0], 1'b0};
            if (div_trial >= cols_eff)
            begin
                rem_reg <= div_trial - cols_eff;
            end
            else
            begin
                rem_reg <= div_trial;
            end
            if (div_cnt_reg == '0)
            begin
                work_col_reg <= (div_trial >= cols_eff) ? (div_trial - cols_eff) : div_trial;
            end
        end
        else if (state_reg == ST_NORM && blank_reg)
        begin
            // A backspace draws the blank cell at the cursor it moved to.
            off_row_reg <= row_clamped[CUR_W-1:0];
            off_col_reg <= work_col_reg[CUR_W-1:0];
        end

        if (state_reg == ST_MUL)
        begin
            base_reg    <= OFFSET_W'(off_row_reg * ph_reg);
            colterm_reg <= CT_W'(off_col_reg * width_eff) << BYTES_PER_PIXEL_SHIFT;
        end

        if (state_reg == ST_ADD)
        begin
            off_reg <= base_reg + OFFSET_W'(colterm_reg);
        end
        else if (load)
        begin
            off_reg <= off_reg + OFFSET_W'(pitch_reg);
        end

        if (load)
        begin
            out_off_reg   <= off_reg;
            out_bits_reg  <= blank_reg ? 8'd0 : glyph_bits;
            out_color_reg <= ink_reg;
            m_tlast_reg   <= last_load;
            out_row_reg   <= cur_row_reg;
            out_col_reg   <= cur_col_reg;
        end
    end

    // Glyph memory: one write port for loads, one registered read port for drawing.
    always_ff @(posedge clk)
    begin
        if (glyph_wr)
        begin
            glyph_mem[in_gaddr] <= in_gbyte;
        end
        if (rd_issue)
        begin
            glyph_rd_reg <= glyph_mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {2'b00, out_col_reg, out_row_reg, out_color_reg, out_bits_reg,
                       out_off_reg};

    // At most one glyph line is read ahead of the output register.
    a_read_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((rd_y_reg == em_y_reg)
                                    || (rd_y_reg == em_y_reg + HEIGHT_W'(1))))
        else $error("glyph read counter drifted from emit counter");

    // A pending read always corresponds to one issued but not yet emitted line.
    a_pend_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rd_pend_reg == (rd_y_reg != em_y_reg)))
        else $error("read pending flag disagrees with counters");

    // The final line of a cell returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        last_load |=> (state_reg == ST_IDLE) && m_tvalid && m_tlast)
        else $error("last line did not close the cell");

    // Glyph store writes never start the sequencer.
    a_glyph_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        glyph_wr |=> (state_reg == ST_IDLE))
        else $error("glyph store write left idle");

    // The remainder unit always leaves a column inside the screen.
    a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_cnt_reg == '0) |=> (work_col_reg < cols_eff))
        else $error("wrapped column out of range");

endmodule
